// File: hdl/multilevel_page_table_defines.svh
// assertion macros for the page table rtl
`ifndef MULTILEVEL_PAGE_TABLE_DEFINES_SVH
`define MULTILEVEL_PAGE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define MLPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MLPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MLPT_ASSERT(lbl, clk, rst, prop, msg)
`define MLPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/mlpt_pkg.sv
`default_nettype none

package mlpt_pkg;

  localparam int ADDR_W        = 32;
  localparam int OUT_FRAME_W   = 20;
  localparam int LEVEL_COUNT_W = 3;
  localparam int LEVEL_BITS_W  = 4;
  localparam int MAX_LEVELS    = 4;
  localparam int LEVEL_W       = 2;
  localparam int SUM_W         = 6;
  localparam int CFG_INDEX_W   = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_BAD_CFG = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_L0     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_L1     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_L2     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_L3     = 3'd4;

  localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RESET = 3'd2;
  localparam logic [LEVEL_BITS_W-1:0]  LEVEL_BITS_RESET  = 4'd8;

endpackage

`default_nettype wire

// File: hdl/multilevel_page_table.sv
// radix page table walk, one transaction in flight at a time
// each level walked is a memory read state, then an evaluate state; result registered
// a new transaction is taken only back in idle; a miss or full pool ends the walk early
// bad configuration answers straight from idle, with no walk
// reset (rst, synchronous): config to defaults, next free node 1, then a clearing pass over all
// NODE_COUNT << MAX_LEVEL_BITS entries of the entry memory with s_tready low
`default_nettype none

`include "multilevel_page_table_defines.svh"

module multilevel_page_table #(
  parameter int MAX_LEVEL_BITS = 8,
  parameter int NODE_COUNT     = 64,
  parameter int FRAME_BITS     = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [55:0]                         s_tdata,  // logical_address[31:0], frame_number[51:32], zero pad
  input  wire logic                                s_tuser,  // opcode
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [23:0]                         m_tdata,  // frame_out[19:0], zero pad
  output logic      [1:0]                          m_tuser,  // status
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mlpt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mlpt_pkg::LEVEL_BITS_W-1:0]   cfg_data
);

  import mlpt_pkg::*;

  // node numbering and memory geometry
  localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FREE_W  = $clog2(NODE_COUNT + 1);
  localparam int SLOT_W  = NODE_W + MAX_LEVEL_BITS;
  localparam int DEPTH   = NODE_COUNT << MAX_LEVEL_BITS;
  // stored frame bits: the input carries 20, storage keeps the low min(FRAME_BITS, 20) of them
  localparam int SF_W    = (FRAME_BITS < OUT_FRAME_W) ? FRAME_BITS : OUT_FRAME_W;
  localparam int PAY_W   = (SF_W > NODE_W) ? SF_W : NODE_W;
  localparam int ENT_W   = PAY_W + 1;
  localparam int CMP_W   = (PAY_W > FREE_W) ? PAY_W : FREE_W;

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(DEPTH - 1);
  localparam logic [FREE_W-1:0] FREE_FULL  = FREE_W'(NODE_COUNT);
  localparam logic [FREE_W-1:0] FREE_FIRST = FREE_W'(1);

  // walk sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;

  // configuration registers
  logic [LEVEL_COUNT_W-1:0] level_count;
  logic [LEVEL_BITS_W-1:0]  lvl_bits [MAX_LEVELS];

  // the transaction being walked
  logic                     op_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [OUT_FRAME_W-1:0]   frame_q;
  logic [LEVEL_W-1:0]       level;
  logic [NODE_W-1:0]        node;
  logic [FREE_W-1:0]        next_free;
  logic [SLOT_W-1:0]        clr_cnt;

  // result waiting for the output register
  logic [1:0]               pend_status;
  logic [OUT_FRAME_W-1:0]   pend_frame;
  logic [1:0]               out_status;
  logic [OUT_FRAME_W-1:0]   out_frame;

  // memory port
  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [SLOT_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;

  // the user must write config only while idle, so a write never races a walk; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_COUNT_RESET;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        lvl_bits[i] <= LEVEL_BITS_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL_COUNT: level_count <= cfg_data[LEVEL_COUNT_W-1:0];
        CFG_BITS_L0:     lvl_bits[0] <= cfg_data;
        CFG_BITS_L1:     lvl_bits[1] <= cfg_data;
        CFG_BITS_L2:     lvl_bits[2] <= cfg_data;
        CFG_BITS_L3:     lvl_bits[3] <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // configuration check: level count, per-level widths, and an offset bit left over
  logic             cfg_bad;
  logic [SUM_W-1:0] used_sum;

  always_comb begin
    cfg_bad  = 1'b0;
    used_sum = '0;
    if (level_count == '0 || level_count > LEVEL_COUNT_W'(MAX_LEVELS)) begin
      cfg_bad = 1'b1;
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (LEVEL_COUNT_W'(i) < level_count) begin
        if (lvl_bits[i] == '0 || lvl_bits[i] > MAX_LEVEL_BITS) begin
          cfg_bad = 1'b1;
        end
        used_sum = used_sum + SUM_W'(lvl_bits[i]);
      end
    end
    if (used_sum >= SUM_W'(ADDR_W)) begin
      cfg_bad = 1'b1;
    end
  end

  // index of the current level, cut from the top of the address
  logic [SUM_W-1:0]          level_top;
  logic [SUM_W-1:0]          shamt;
  logic [ADDR_W-1:0]         addr_sh;
  logic [MAX_LEVEL_BITS-1:0] lvl_mask;
  logic [MAX_LEVEL_BITS-1:0] lvl_idx;
  logic [SLOT_W-1:0]         slot;

  always_comb begin
    level_top = '0;
    for (int j = 0; j < MAX_LEVELS; j++) begin
      if (LEVEL_W'(j) <= level) begin
        level_top = level_top + SUM_W'(lvl_bits[j]);
      end
    end
    shamt    = SUM_W'(ADDR_W) - level_top;
    addr_sh  = addr_q >> shamt[4:0];
    lvl_mask = ~({MAX_LEVEL_BITS{1'b1}} << lvl_bits[level]);
    lvl_idx  = addr_sh[MAX_LEVEL_BITS-1:0] & lvl_mask;
    slot     = {node, lvl_idx};
  end

  assign ram_raddr = slot;

  // entry read in the previous cycle
  logic             ent_valid;
  logic [PAY_W-1:0] ent_pay;
  logic             child_ok;
  logic             leaf;

  assign ent_valid = ram_rdata[PAY_W];
  assign ent_pay   = ram_rdata[PAY_W-1:0];
  // stale children (zero or not yet handed out) count as absent
  assign child_ok  = ent_valid && (ent_pay != '0) && (CMP_W'(ent_pay) < CMP_W'(next_free));
  assign leaf      = ({1'b0, level} == (level_count - LEVEL_COUNT_W'(1)));

  logic s_fire;
  logic out_free;
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // per-state decisions: result, memory write, descent
  logic                   emit;
  logic [1:0]             emit_status;
  logic [OUT_FRAME_W-1:0] emit_frame;
  logic                   descend;
  logic                   alloc;

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_frame  = '0;
    descend     = 1'b0;
    alloc       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot;
    ram_wdata   = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (s_fire && cfg_bad) begin
          emit        = 1'b1;
          emit_status = ST_BAD_CFG;
        end
      end
      S_EVAL: begin
        if (!leaf) begin
          if (child_ok) begin
            descend = 1'b1;
          end else if (op_q == OP_LOOKUP) begin
            emit        = 1'b1;
            emit_status = ST_MISS;
          end else if (next_free == FREE_FULL) begin
            emit        = 1'b1;
            emit_status = ST_NO_FREE;
          end else begin
            // link a fresh node; the clearing pass left it empty
            alloc     = 1'b1;
            descend   = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = {1'b1, PAY_W'(next_free)};
          end
        end else if (op_q == OP_LOOKUP) begin
          emit = 1'b1;
          if (ent_valid) begin
            emit_status = ST_OK;
            emit_frame  = OUT_FRAME_W'(ent_pay[SF_W-1:0]);
          end else begin
            emit_status = ST_MISS;
          end
        end else begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_frame  = OUT_FRAME_W'(frame_q[SF_W-1:0]);
          ram_we      = 1'b1;
          ram_wdata   = {1'b1, PAY_W'(frame_q[SF_W-1:0])};
        end
      end
      default: ;
    endcase
  end

  // output register loads from a fresh result or from the pending one
  logic load_out;
  assign load_out = out_free && (emit || (state == S_RESULT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= FREE_FIRST;
      m_tvalid  <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (alloc) begin
        next_free <= next_free + FREE_FIRST;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == SLOT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            if (cfg_bad) begin
              state <= out_free ? S_IDLE : S_RESULT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (descend) begin
            state <= S_READ;
          end else if (emit) begin
            state <= out_free ? S_IDLE : S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_q    <= s_tuser;
      addr_q  <= s_tdata[ADDR_W-1:0];
      frame_q <= s_tdata[ADDR_W +: OUT_FRAME_W];
      level   <= '0;
      node    <= '0;
    end else if (descend) begin
      level <= level + LEVEL_W'(1);
      node  <= alloc ? next_free[NODE_W-1:0] : ent_pay[NODE_W-1:0];
    end
    if (emit) begin
      pend_status <= emit_status;
      pend_frame  <= emit_frame;
    end
    if (load_out) begin
      out_status <= emit ? emit_status : pend_status;
      out_frame  <= emit ? emit_frame : pend_frame;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {4'b0000, out_frame};

  mlpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // no input taken while the entry memory is being cleared
  `MLPT_ASSERT(a_no_accept_clear, clk, rst, (state == S_CLEAR) |-> !s_tready, "accept during clear")
  // the pool counter never passes the pool size
  `MLPT_ASSERT(a_free_bound, clk, rst, next_free <= FREE_FULL, "next free node out of range")
  // outside the clearing pass only inserts write the memory
  `MLPT_ASSERT(a_write_insert, clk, rst, (ram_we && state != S_CLEAR) |-> (op_q == OP_INSERT), "write from a lookup")
  // an accepted transaction either starts a walk or has its result on the way
  `MLPT_ASSERT(a_accept_moves, clk, rst, s_fire |=> (state != S_IDLE) || m_tvalid, "accepted transaction dropped")
  // reset restarts the clearing pass with only the root in use
  `MLPT_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (state == S_CLEAR) && (next_free == FREE_FIRST), "bad state after reset")

endmodule

`default_nettype wire

// File: hdl/mlpt_ram.sv
`default_nettype none

module mlpt_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
